/* hw/rtl/overwrite_oldest_rx_ring_buffer_assert.svh */
// Assertion macros for the overwrite-oldest receive ring buffer
`ifndef OVERWRITE_OLDEST_RX_RING_BUFFER_ASSERT_SVH
`define OVERWRITE_OLDEST_RX_RING_BUFFER_ASSERT_SVH
`ifndef SYNTH
// expr must hold at every edge outside reset
`define OORB_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("ring buffer assertion failed");
// ante implies cons from the same edge
`define OORB_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("ring buffer assertion failed");
`else
`define OORB_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define OORB_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/oorb_pkg.sv */
// Package: types, constants and helpers for the overwrite-oldest receive ring buffer
`timescale 1ns / 1ps
package oorb_pkg;

   localparam int DEPTH  = 128;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = 7;

   localparam logic [1:0] OP_RECEIVE  = 2'd0;
   localparam logic [1:0] OP_READ     = 2'd1;
   localparam logic [1:0] OP_FLUSH    = 2'd2;
   localparam logic [1:0] OP_TAKE_OVF = 2'd3;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]        read_byte;
      logic              was_empty;
      logic [FILL_W-1:0] fill_count;
      logic              overflow_seen;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctl_cmd_type;

   function automatic ptr_type ring_next(ptr_type p);
      ptr_type r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + ptr_type'(1);
      return r;
   endfunction

   function automatic logic [FILL_W-1:0] ring_fill(ptr_type wr, ptr_type rd);
      logic [PTR_W:0] d;
      if (wr >= rd) begin
         d = {1'b0, wr} - {1'b0, rd};
      end else begin
         d = {1'b0, wr} + (PTR_W+1)'(DEPTH) - {1'b0, rd};
      end
      return FILL_W'(d);
   endfunction

endpackage

/* hw/rtl/oorb_ctrl.sv */
// Controller: sequences capture, execute and response of each transaction
`timescale 1ns / 1ps
module oorb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   output oorb_pkg::ctl_cmd_type cmd
);
   import oorb_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign busy   = (state_ff == ST_EXEC);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_strobe = (state_ff == ST_RESP);
   assign cmd.load   = accept;
   assign cmd.exec   = (state_ff == ST_EXEC);

endmodule

/* hw/rtl/oorb_dp.sv */
// Datapath: byte store, pointers, overflow flag and response register
`timescale 1ns / 1ps
module oorb_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  oorb_pkg::ctl_cmd_type cmd,
   input  oorb_pkg::req_type     req_data,
   output oorb_pkg::rsp_type     rsp_data
);
   import oorb_pkg::*;

   logic [7:0] byte_store [DEPTH];
   logic [7:0] mem_q_ff;

   req_type req_ff;
   ptr_type wr_ptr_ff, wr_ptr_in;
   ptr_type rd_ptr_ff, rd_ptr_in;
   logic    ovf_ff, ovf_in;
   rsp_type rsp_ff, rsp_in;
   logic    do_write;
   ptr_type wr_next;

   assign wr_next  = ring_next(wr_ptr_ff);
   assign do_write = cmd.exec && (req_ff.opcode == OP_RECEIVE);

   always_ff @(posedge clock) begin
      if (do_write) byte_store[wr_ptr_ff] <= req_ff.rx_byte;
      mem_q_ff <= byte_store[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      ovf_in    = ovf_ff;
      rsp_in    = '0;
      case (req_ff.opcode)
         OP_RECEIVE: begin
            if (wr_next == rd_ptr_ff) begin
               rd_ptr_in = ring_next(rd_ptr_ff);
               ovf_in    = 1'b1;
            end
            wr_ptr_in = wr_next;
         end
         OP_READ: begin
            if (wr_ptr_ff == rd_ptr_ff) begin
               rsp_in.was_empty = 1'b1;
            end else begin
               rsp_in.read_byte = mem_q_ff;
               rd_ptr_in        = ring_next(rd_ptr_ff);
            end
         end
         OP_FLUSH: begin
            wr_ptr_in = rd_ptr_ff;
            ovf_in    = 1'b0;
         end
         OP_TAKE_OVF: begin
            rsp_in.overflow_seen = ovf_ff;
            ovf_in               = 1'b0;
         end
         default: begin
            ovf_in = ovf_ff;
         end
      endcase
      rsp_in.fill_count = ring_fill(wr_ptr_in, rd_ptr_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         ovf_ff    <= 1'b0;
      end else if (cmd.exec) begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

/* hw/rtl/overwrite_oldest_rx_ring_buffer.sv */
// Top level: overwrite-oldest receive ring buffer
//
//  channel   ports                          handshake
//  request   start, busy, req_data          taken when start && !busy
//  response  rsp_strobe, rsp_data           one cycle per transaction, no back-pressure
//
// A transaction is taken at one edge, executed in the next cycle (busy high) and
// its response strobed in the cycle after; a new transaction may be taken while
// the response is shown, so one every 2 cycles, set by the registered store read.
// Synchronous reset empties the buffer and clears the overflow flag; store
// contents are left as they were.
`timescale 1ns / 1ps
`include "overwrite_oldest_rx_ring_buffer_assert.svh"
module overwrite_oldest_rx_ring_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  oorb_pkg::req_type req_data,
   output logic              rsp_strobe,
   output oorb_pkg::rsp_type rsp_data
);
   import oorb_pkg::*;

   ctl_cmd_type cmd;

   oorb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   oorb_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   `OORB_ASSERT_IMPLIES(a_rsp_after_accept, clock, reset, start && !busy, ##2 rsp_strobe)
   `OORB_ASSERT_ALWAYS(a_no_busy_strobe, clock, reset, !(busy && rsp_strobe))
   `OORB_ASSERT_IMPLIES(a_strobe_single, clock, reset, rsp_strobe, !$past(rsp_strobe))
   `OORB_ASSERT_IMPLIES(a_empty_clean, clock, reset, rsp_strobe && rsp_data.was_empty,
                        (rsp_data.read_byte == 8'd0) && !rsp_data.overflow_seen)

endmodule
